### rtl/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 18;

    // Quaternion component that carries the square root term
    typedef enum logic [1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } slot_t;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion, Shepperd's method, fully pipelined.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: m00..m22 (Q2.16 default)
//  m_        out  m_tvalid/m_tready  m_tdata: quat_w..quat_z, m_tuser: status
//
// One matrix enters per cycle unless a stall on m_tready holds the pipeline;
// it passes the front end, the bit-serial square root (one root bit per stage),
// the three-lane divider (one quotient bit per stage) and an output register.
// aresetn is synchronous and clears only the valid bits.
// A stall on m_tready freezes every stage at once; nothing is dropped or repeated.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    // status
    output logic                                  m_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int RADW  = ((DW > FB) ? DW : FB) + 3;
    localparam int MAGW  = DW + 1;
    localparam int RTW   = (RADW - 1 + FB + 1) / 2;
    localparam int NUMW  = (((DW + FB) > RTW) ? (DW + FB) : RTW) + 1;
    localparam int SQSB  = 3*MAGW + 6;
    localparam int DVSB  = RTW + 6;
    localparam int MDW   = ((4*DW+7)/8)*8;

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic                 f_valid, f_bad;
    logic [RADW-2:0]      f_rad;
    logic [2:0][MAGW-1:0] f_mag;
    logic [2:0]           f_neg;
    slot_t                f_slot;

    rmq_front #(.DW(DW), .FB(FB), .RADW(RADW), .MAGW(MAGW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_mat    (s_tdata[9*DW-1:0]),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_mag   (f_mag),
        .out_neg   (f_neg),
        .out_slot  (f_slot),
        .out_bad   (f_bad)
    );

    logic [2*RTW-1:0] sq_val;
    logic [SQSB-1:0]  sq_sb_in, sq_sb_out;
    logic             sq_valid;
    logic [RTW-1:0]   sq_root;

    assign sq_val   = (2*RTW)'({f_rad, {FB{1'b0}}});
    assign sq_sb_in = {f_mag, f_neg, f_slot, f_bad};

    rmq_sqrt #(.RTW(RTW), .SBW(SQSB)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_val    (sq_val),
        .in_sb     (sq_sb_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb_out)
    );

    logic [2:0][MAGW-1:0] sq_mag;
    logic [DVSB-1:0]      dv_sb_in, dv_sb_out;
    logic                 dv_valid;
    logic [2:0][NUMW-1:0] dv_quo;

    assign sq_mag   = sq_sb_out[SQSB-1 -: 3*MAGW];
    assign dv_sb_in = {sq_root, sq_sb_out[5:0]};

    rmq_div #(.RTW(RTW), .MAGW(MAGW), .FB(FB), .NUMW(NUMW), .SBW(DVSB)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_mag    (sq_mag),
        .in_sb     (dv_sb_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb_out)
    );

    function automatic logic [DW-1:0] sat_out(input logic neg, input logic [NUMW-1:0] mag);
        logic [NUMW-1:0] lim;
        logic [NUMW-1:0] tmp;
        lim = NUMW'(1) << (DW - 1);
        tmp = ~mag + NUMW'(1);
        if (neg) begin
            sat_out = (mag > lim) ? {1'b1, {(DW-1){1'b0}}} : tmp[DW-1:0];
        end else begin
            sat_out = (mag > lim - NUMW'(1)) ? {1'b0, {(DW-1){1'b1}}} : mag[DW-1:0];
        end
    endfunction

    logic [RTW-1:0]    o_root;
    logic [2:0]        o_neg;
    slot_t             o_slot;
    logic              o_bad;
    logic [RTW:0]      lead_sum;
    logic [DW-1:0]     lead_q;
    logic [DW-1:0]     t_q [0:2];
    logic [DW-1:0]     q_s [0:3];
    logic [MDW-1:0]    tdata_next;
    logic [MDW-1:0]    m_tdata_reg;
    logic              m_tuser_reg;

    assign o_root = dv_sb_out[DVSB-1 -: RTW];
    assign o_neg  = dv_sb_out[5:3];
    assign o_slot = slot_t'(dv_sb_out[2:1]);
    assign o_bad  = dv_sb_out[0];

    always_comb begin
        lead_sum = {1'b0, o_root} + (RTW+1)'(1);
        lead_q   = sat_out(1'b0, NUMW'(lead_sum[RTW:1]));
        for (int l = 0; l < 3; l++) begin
            t_q[l] = sat_out(o_neg[l], dv_quo[l]);
        end
        // leading term goes to its slot, the sums fill the rest in order
        unique case (o_slot)
            SLOT_W: begin
                q_s[0] = lead_q; q_s[1] = t_q[0]; q_s[2] = t_q[1]; q_s[3] = t_q[2];
            end
            SLOT_X: begin
                q_s[0] = t_q[0]; q_s[1] = lead_q; q_s[2] = t_q[1]; q_s[3] = t_q[2];
            end
            SLOT_Y: begin
                q_s[0] = t_q[0]; q_s[1] = t_q[1]; q_s[2] = lead_q; q_s[3] = t_q[2];
            end
            SLOT_Z: begin
                q_s[0] = t_q[0]; q_s[1] = t_q[1]; q_s[2] = t_q[2]; q_s[3] = lead_q;
            end
            default: begin
                q_s[0] = '0; q_s[1] = '0; q_s[2] = '0; q_s[3] = '0;
            end
        endcase
        tdata_next = '0;
        if (!o_bad) begin
            for (int c = 0; c < 4; c++) begin
                tdata_next[c*DW +: DW] = q_s[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= o_bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/rmq_front.sv
// Front end: trace, pivot selection, radicand and off-diagonal sums in two stages.
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
    parameter int DW   = DATA_WIDTH_DEF,
    parameter int FB   = FRAC_BITS_DEF,
    parameter int RADW = ((DW > FB) ? DW : FB) + 3,
    parameter int MAGW = DW + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [9*DW-1:0]           in_mat,
    output logic                      out_valid,
    output logic [RADW-2:0]           out_rad,
    output logic [2:0][MAGW-1:0]      out_mag,
    output logic [2:0]                out_neg,
    output slot_t                     out_slot,
    output logic                      out_bad
);

    localparam logic signed [RADW-1:0] ONE_R = RADW'(1) << FB;

    logic                   v1_reg;
    logic signed [DW-1:0]   m_reg [0:8];
    logic signed [RADW-1:0] trace_reg;
    slot_t                  slot1_reg;

    logic signed [DW-1:0]   m_in [0:8];
    logic signed [RADW-1:0] trace_next;
    slot_t                  slot1_next;

    function automatic logic signed [RADW-1:0] ext(input logic signed [DW-1:0] a);
        ext = RADW'(a);
    endfunction

    function automatic logic signed [MAGW-1:0] sub_e(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        sub_e = MAGW'(a) - MAGW'(b);
    endfunction

    function automatic logic signed [MAGW-1:0] add_e(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        add_e = MAGW'(a) + MAGW'(b);
    endfunction

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            m_in[e] = in_mat[e*DW +: DW];
        end
        trace_next = ext(m_in[0]) + ext(m_in[4]) + ext(m_in[8]);
        if (trace_next > 0) begin
            slot1_next = SLOT_W;
        end else if (m_in[8] > m_in[0] && m_in[8] > m_in[4]) begin
            slot1_next = SLOT_Z;
        end else if (m_in[4] > m_in[0]) begin
            // first of equal maxima wins
            slot1_next = (m_in[8] > m_in[4]) ? SLOT_Z : SLOT_Y;
        end else begin
            slot1_next = SLOT_X;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int e = 0; e < 9; e++) begin
                m_reg[e] <= m_in[e];
            end
            trace_reg <= trace_next;
            slot1_reg <= slot1_next;
        end
    end

    // second stage
    logic signed [RADW-1:0]  rad_s;
    logic signed [MAGW-1:0]  t_s [0:2];
    logic                    v2_reg;
    logic [RADW-2:0]         rad_reg, rad_next;
    logic [2:0][MAGW-1:0]    mag_reg, mag_next;
    logic [2:0]              neg_reg, neg_next;
    slot_t                   slot2_reg;
    logic                    bad_reg, bad_next;

    always_comb begin
        unique case (slot1_reg)
            SLOT_W: begin
                rad_s  = trace_reg + ONE_R;
                t_s[0] = sub_e(m_reg[7], m_reg[5]);
                t_s[1] = sub_e(m_reg[2], m_reg[6]);
                t_s[2] = sub_e(m_reg[3], m_reg[1]);
            end
            SLOT_X: begin
                rad_s  = ext(m_reg[0]) - ext(m_reg[4]) - ext(m_reg[8]) + ONE_R;
                t_s[0] = sub_e(m_reg[7], m_reg[5]);
                t_s[1] = add_e(m_reg[3], m_reg[1]);
                t_s[2] = add_e(m_reg[6], m_reg[2]);
            end
            SLOT_Y: begin
                rad_s  = ext(m_reg[4]) - ext(m_reg[8]) - ext(m_reg[0]) + ONE_R;
                t_s[0] = sub_e(m_reg[2], m_reg[6]);
                t_s[1] = add_e(m_reg[1], m_reg[3]);
                t_s[2] = add_e(m_reg[7], m_reg[5]);
            end
            SLOT_Z: begin
                rad_s  = ext(m_reg[8]) - ext(m_reg[0]) - ext(m_reg[4]) + ONE_R;
                t_s[0] = sub_e(m_reg[3], m_reg[1]);
                t_s[1] = add_e(m_reg[2], m_reg[6]);
                t_s[2] = add_e(m_reg[5], m_reg[7]);
            end
            default: begin
                rad_s  = '0;
                t_s[0] = '0;
                t_s[1] = '0;
                t_s[2] = '0;
            end
        endcase
        bad_next = (rad_s <= 0);
        rad_next = bad_next ? '0 : rad_s[RADW-2:0];
        for (int l = 0; l < 3; l++) begin
            neg_next[l] = t_s[l][MAGW-1];
            mag_next[l] = neg_next[l] ? MAGW'(-t_s[l]) : MAGW'(t_s[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg   <= rad_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            slot2_reg <= slot1_reg;
            bad_reg   <= bad_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rad   = rad_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_slot  = slot2_reg;
    assign out_bad   = bad_reg;

endmodule

### rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rmq_sqrt import rmq_pkg::*; #(
    parameter int RTW = DATA_WIDTH_DEF,
    parameter int SBW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RTW-1:0]  in_val,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [RTW-1:0]    out_root,
    output logic [SBW-1:0]    out_sb
);

    localparam int VE   = 2 * RTW;
    localparam int REMW = RTW + 3;

    logic            valid_reg [0:RTW-1];
    logic [REMW-1:0] rem_reg   [0:RTW-1];
    logic [RTW-1:0]  root_reg  [0:RTW-1];
    logic [VE-1:0]   val_reg   [0:RTW-1];
    logic [SBW-1:0]  sb_reg    [0:RTW-1];

    for (genvar s = 0; s < RTW; s++) begin : g_stage
        logic            v_in;
        logic [REMW-1:0] rem_in;
        logic [RTW-1:0]  root_in;
        logic [VE-1:0]   val_in;
        logic [SBW-1:0]  sb_in;
        logic [REMW-1:0] cur, trial, rem_next;
        logic [RTW-1:0]  root_next;
        logic [VE-1:0]   val_next;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = in_val;
            assign sb_in   = in_sb;
        end else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
            assign sb_in   = sb_reg[s-1];
        end

        always_comb begin
            cur   = {rem_in[REMW-3:0], val_in[VE-1 -: 2]};
            trial = REMW'({root_in, 2'b01});
            if (cur >= trial) begin
                rem_next  = cur - trial;
                root_next = {root_in[RTW-2:0], 1'b1};
            end else begin
                rem_next  = cur;
                root_next = {root_in[RTW-2:0], 1'b0};
            end
            val_next = val_in << 2;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                val_reg[s]  <= val_next;
                sb_reg[s]   <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[RTW-1];
    assign out_root  = root_reg[RTW-1];
    assign out_sb    = sb_reg[RTW-1];

endmodule

### rtl/rmq_div.sv
// Three-lane pipelined restoring divider sharing one divisor, rounded to nearest.
`timescale 1ns / 1ps

module rmq_div import rmq_pkg::*; #(
    parameter int RTW  = DATA_WIDTH_DEF,
    parameter int MAGW = DATA_WIDTH_DEF + 1,
    parameter int FB   = FRAC_BITS_DEF,
    parameter int NUMW = DATA_WIDTH_DEF + FRAC_BITS_DEF + 1,
    parameter int SBW  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RTW-1:0]        in_root,
    input  logic [2:0][MAGW-1:0]  in_mag,
    input  logic [SBW-1:0]        in_sb,
    output logic                  out_valid,
    output logic [2:0][NUMW-1:0]  out_quo,
    output logic [SBW-1:0]        out_sb
);

    localparam int DREMW = RTW + 2;

    // prep stage: numerator gets half the divisor added for rounding
    logic                 pv_reg;
    logic [2:0][NUMW-1:0] pnum_reg, pnum_next;
    logic [RTW:0]         pd_reg;
    logic [SBW-1:0]       psb_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            pnum_next[l] = (NUMW'(in_mag[l]) << FB) + NUMW'(in_root);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pnum_reg <= pnum_next;
            pd_reg   <= {in_root, 1'b0};
            psb_reg  <= in_sb;
        end
    end

    logic                  valid_reg [0:NUMW-1];
    logic [2:0][DREMW-1:0] rem_reg   [0:NUMW-1];
    logic [2:0][NUMW-1:0]  num_reg   [0:NUMW-1];
    logic [2:0][NUMW-1:0]  quo_reg   [0:NUMW-1];
    logic [RTW:0]          d_reg     [0:NUMW-1];
    logic [SBW-1:0]        sb_reg    [0:NUMW-1];

    for (genvar s = 0; s < NUMW; s++) begin : g_stage
        logic                  v_in;
        logic [2:0][DREMW-1:0] rem_in;
        logic [2:0][NUMW-1:0]  num_in, quo_in;
        logic [RTW:0]          d_in;
        logic [SBW-1:0]        sb_in;
        logic [2:0][DREMW-1:0] rem_next;
        logic [2:0][NUMW-1:0]  num_next, quo_next;
        logic [DREMW-1:0]      cur;

        if (s == 0) begin : g_first
            assign v_in   = pv_reg;
            assign rem_in = '0;
            assign num_in = pnum_reg;
            assign quo_in = '0;
            assign d_in   = pd_reg;
            assign sb_in  = psb_reg;
        end else begin : g_rest
            assign v_in   = valid_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign d_in   = d_reg[s-1];
            assign sb_in  = sb_reg[s-1];
        end

        always_comb begin
            cur = '0;
            for (int l = 0; l < 3; l++) begin
                cur = {rem_in[l][DREMW-2:0], num_in[l][NUMW-1]};
                if (cur >= DREMW'(d_in)) begin
                    rem_next[l] = cur - DREMW'(d_in);
                    quo_next[l] = {quo_in[l][NUMW-2:0], 1'b1};
                end else begin
                    rem_next[l] = cur;
                    quo_next[l] = {quo_in[l][NUMW-2:0], 1'b0};
                end
                num_next[l] = num_in[l] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                num_reg[s] <= num_next;
                quo_reg[s] <= quo_next;
                d_reg[s]   <= d_in;
                sb_reg[s]  <= sb_in;
            end
        end
    end

    assign out_valid = valid_reg[NUMW-1];
    assign out_quo   = quo_reg[NUMW-1];
    assign out_sb    = sb_reg[NUMW-1];

endmodule

### tb/rotation_matrix_to_quaternion_checker.sv
// Checker for the matrix to quaternion pipeline: predicts each result and compares it.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_checker import rmq_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SW = ((9*DATA_WIDTH+7)/8)*8,
    parameter int MW = ((4*DATA_WIDTH+7)/8)*8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [SW-1:0] s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [MW-1:0] m_tdata,
    input  logic          m_tuser,
    output int            fail_count,
    output int            pending
);

    typedef struct {
        logic [DATA_WIDTH-1:0] comp [4];
        logic                  status;
    } quat_t;

    quat_t quat_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clamp(bit neg, longint unsigned mag);
        longint unsigned lim;
        longint r;
        lim = 64'd1 << (DATA_WIDTH - 1);
        if (neg) begin
            if (mag > lim) mag = lim;
            r = -longint'(mag);
        end else begin
            if (mag > lim - 1) mag = lim - 1;
            r = longint'(mag);
        end
        return r[DATA_WIDTH-1:0];
    endfunction

    // Rounded |s| / (2 root) in the fixed-point format, ties away from zero.
    function automatic logic [DATA_WIDTH-1:0] div_round(longint s, longint unsigned root);
        longint unsigned mag;
        mag = (s < 0) ? longint'(-s) : s;
        return clamp(s < 0, ((mag << FRAC_BITS) + root) / (root * 2));
    endfunction

    function automatic quat_t convert(logic [SW-1:0] d);
        longint m [3][3];
        longint one, tr, rad;
        longint unsigned root;
        int i, j, k;
        quat_t q;
        one = longint'(1) << FRAC_BITS;
        for (int n = 0; n < 9; n++)
            m[n/3][n%3] = longint'($signed(d[n*DATA_WIDTH +: DATA_WIDTH]));
        q.status = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            root = int_sqrt(longint'(tr + one) << FRAC_BITS);
            q.comp[SLOT_W] = clamp(0, (root + 1) >> 1);
            q.comp[SLOT_X] = div_round(m[2][1] - m[1][2], root);
            q.comp[SLOT_Y] = div_round(m[0][2] - m[2][0], root);
            q.comp[SLOT_Z] = div_round(m[1][0] - m[0][1], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            rad = m[i][i] - m[j][j] - m[k][k] + one;
            if (rad <= 0) begin
                for (int n = 0; n < 4; n++) q.comp[n] = '0;
                q.status = 1'b1;
            end else begin
                root = int_sqrt(rad << FRAC_BITS);
                q.comp[i+1] = clamp(0, (root + 1) >> 1);
                q.comp[SLOT_W] = div_round(m[k][j] - m[j][k], root);
                q.comp[j+1] = div_round(m[j][i] + m[i][j], root);
                q.comp[k+1] = div_round(m[k][i] + m[i][k], root);
            end
        end
        return q;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        quat_t want;
        if (aresetn && s_tvalid && s_tready)
            quat_q.push_back(convert(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (quat_q.size() == 0) begin
                report("unexpected transfer", 1, 0);
            end else begin
                want = quat_q.pop_front();
                for (int n = 0; n < 4; n++)
                    if (m_tdata[n*DATA_WIDTH +: DATA_WIDTH] !== want.comp[n])
                        report($sformatf("quat component %0d", n),
                               $signed(m_tdata[n*DATA_WIDTH +: DATA_WIDTH]),
                               $signed(want.comp[n]));
                if (m_tuser !== want.status)
                    report("status", m_tuser, want.status);
            end
        end
        pending <= quat_q.size();
    end

endmodule

### tb/rotation_matrix_to_quaternion_test.sv
// Testbench top: drives matrices into the pipeline and gives the verdict.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int SW = ((9*DW+7)/8)*8;
    localparam int MW = ((4*DW+7)/8)*8;
    localparam int ONE = 1 << FB;
    localparam int WATCHDOG = 5000;
    localparam int N_RANDOM = 900;
    localparam int TAIL = 150;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;
    logic          m_tuser;
    int            fail_count;
    int            pending;
    int            idle_cycles;
    bit            sink_calm;
    bit            hold_sink;

    rotation_matrix_to_quaternion u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rotation_matrix_to_quaternion_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [SW-1:0] pack(int e [9]);
        logic [SW-1:0] d;
        d = '0;
        for (int n = 0; n < 9; n++) d[n*DW +: DW] = e[n][DW-1:0];
        return d;
    endfunction

    function automatic int rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -(1 << (DW-1));
        if (r == 1) return (1 << (DW-1)) - 1;
        if (r < 5) return int'($urandom_range(0, 2*ONE)) - ONE;
        return int'($urandom_range(0, (1 << DW) - 1)) - (1 << (DW-1));
    endfunction

    // Near-rotation (permuted signed axes, noise) or random: all branches occur.
    function automatic logic [SW-1:0] rand_matrix();
        int e [9];
        int perm, sgn, c, a, b;
        if ($urandom_range(0, 3) == 0) begin
            for (int n = 0; n < 9; n++) e[n] = rand_entry();
        end else begin
            perm = $urandom_range(0, 5);
            c = ONE * 7 / 10;
            for (int n = 0; n < 9; n++) e[n] = int'($urandom_range(0, 2000)) - 1000;
            for (int r = 0; r < 3; r++) begin
                sgn = $urandom_range(0, 1) ? 1 : -1;
                e[r*3 + ((r + perm) % 3)] += sgn * ($urandom_range(0, 1) ? ONE : c);
            end
            a = $urandom_range(0, 8);
            b = $urandom_range(0, 8);
            e[a] += int'($urandom_range(0, c)) - c/2;
            e[b] -= int'($urandom_range(0, c)) - c/2;
        end
        return pack(e);
    endfunction

    task automatic send(logic [SW-1:0] d, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sink: random stall bursts, one long hold, calm at the end.
    initial begin
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink && !held) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                held = 1'b1;
            end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int e [9];
        int mx, mn;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sink_calm = 1'b0;
        hold_sink = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        mx = (1 << (DW-1)) - 1;
        mn = -(1 << (DW-1));
        // identity and the three half-turns: each branch leads once
        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        send(pack(e), 0);
        e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
        send(pack(e), 0);
        e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
        send(pack(e), 0);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
        send(pack(e), 0);
        // equal diagonal maxima: first one wins
        e = '{-ONE/3, 100, -200, 300, -ONE/3, 50, -70, 9, -ONE/3};
        send(pack(e), 0);
        // non-positive trace
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
        send(pack(e), 0);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send(pack(e), 0);
        // extremes, saturating outputs
        e = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
        send(pack(e), 0);
        e = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
        send(pack(e), 0);
        e = '{-ONE + 1, mx, mn, mn, -ONE + 1, mx, mx, mn, 1};
        send(pack(e), 0);
        e = '{mx, mn, mx, mn, mn, mx, mx, mn, mn};
        send(pack(e), 0);
        e = '{mn, mx, mn, mx, mx, mn, mn, mx, mx};
        send(pack(e), 0);
        e = '{1, mn, mx, mx, 0, mn, mn, mx, 0};
        send(pack(e), 0);
        s_tvalid <= 1'b0;
        // pause until drained
        @(posedge aclk iff pending == 0);

        // long sink hold while the source keeps offering
        hold_sink = 1'b1;
        for (int n = 0; n < 150; n++) send(rand_matrix(), 0);
        for (int n = 0; n < N_RANDOM - 250; n++) send(rand_matrix(), 1);
        sink_calm = 1'b1;
        for (int n = 0; n < 100; n++) send(rand_matrix(), 0);
        s_tvalid <= 1'b0;

        @(posedge aclk iff pending == 0);
        repeat (TAIL) @(posedge aclk);
        if (fail_count == 0 && pending == 0 && !m_tvalid)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
